// File: rtl/rect_pkg.sv
// ---------------------------------------------------------------------------
// rect_pkg
// Shared types, constants and the bitsliced inverse S-box for the
// RECTANGLE-64 decryption core.
// ---------------------------------------------------------------------------
package rect_pkg;

    localparam int RECT_ROUNDS = 25;
    localparam int ROW_W       = 16;
    localparam int ROWS        = 4;
    localparam int BLOCK_W     = ROWS * ROW_W;
    localparam int KEY_IDX_W   = 5;
    localparam int IN_FIELDS_W = KEY_IDX_W + 2 * BLOCK_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Columns handled per cycle by the S-box slice while it is not stalled
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = ROW_W / DIGIT_W;
    localparam int DCNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // Inverse row rotations (right)
    localparam int ROT_B = 1;
    localparam int ROT_D = 12;
    localparam int ROT_E = 13;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [ROW_W-1:0]   row_t;

    typedef struct packed {
        digit_t e;
        digit_t d;
        digit_t b;
        digit_t a;
    } col_slice_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_ROUND
    } state_t;

    function automatic row_t rotr_row(input row_t v, input int n);
        return row_t'((v >> n) | (v << (ROW_W - n)));
    endfunction

    function automatic col_slice_t inv_sbox(input digit_t a_in, input digit_t b_in,
                                            input digit_t d_in, input digit_t e_in);
        digit_t     a;
        digit_t     b;
        digit_t     d;
        digit_t     e;
        digit_t     t;
        col_slice_t res;
        a = a_in;
        b = b_in;
        d = d_in;
        e = e_in;
        t = a;
        a = a & d;
        a = a ^ e;
        e = e | t;
        e = e ^ d;
        b = b ^ e;
        d = b;
        b = b ^ t;
        b = b ^ a;
        e = ~e;
        t = e;
        e = e | b;
        e = e ^ a;
        a = a & b;
        a = a ^ t;
        res.a = a;
        res.b = b;
        res.d = d;
        res.e = e;
        return res;
    endfunction

endpackage

// File: rtl/rect_ram.sv
// ---------------------------------------------------------------------------
// rect_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rect_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rectangle_block_decrypt.sv
// ---------------------------------------------------------------------------
// rectangle_block_decrypt
// RECTANGLE-64 decryption with round keys loaded beforehand.
// ---------------------------------------------------------------------------
// A transaction with tuser low writes one round key into the key RAM (indexes
// above ROUNDS are dropped); one with tuser high decrypts one block. A decrypt
// first adds the key that is read from the key RAM at acceptance, then runs
// ROUNDS rounds in which the S-box slice handles four columns a cycle while
// the rows rotate through it (unless held in the last round), and then loads
// the result register. The block returns to idle as the result register
// loads and then takes the next transaction. The input side is ready
// whenever no decrypt is in flight; a result waiting on the output does not
// block loads or the next decrypt, which only holds in its last round until
// the output register frees.
module rectangle_block_decrypt
    import rect_pkg::*;
#(
    parameter int ROUNDS = RECT_ROUNDS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // key_index [4:0], key_value [68:5], block_in [132:69], zero fill above
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // action [0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // block_out [63:0]
    output logic [BLOCK_W-1:0]    m_axis_tdata
);

    localparam int KEY_DEPTH = ROUNDS + 1;
    localparam int AW        = $clog2(KEY_DEPTH);
    localparam int CW        = (AW > KEY_IDX_W) ? AW : KEY_IDX_W;

    // Input fields
    logic                 in_action;
    logic [KEY_IDX_W-1:0] in_key_index;
    logic [BLOCK_W-1:0]   in_key_value;
    logic [BLOCK_W-1:0]   in_block;
    logic                 in_accept;

    assign in_action    = s_axis_tuser;
    assign in_key_index = s_axis_tdata[KEY_IDX_W-1:0];
    assign in_key_value = s_axis_tdata[KEY_IDX_W +: BLOCK_W];
    assign in_block     = s_axis_tdata[KEY_IDX_W + BLOCK_W +: BLOCK_W];
    assign in_accept    = s_axis_tvalid && s_axis_tready;

    // Registers
    state_t             state_reg, state_next;
    logic [AW-1:0]      round_reg, round_next;
    logic [DCNT_W-1:0]  digit_reg, digit_next;
    row_t               cur_reg [ROWS];
    row_t               cur_next [ROWS];
    row_t               nxt_reg [ROWS];
    row_t               nxt_next [ROWS];
    logic [BLOCK_W-1:0] out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    // Key RAM
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BLOCK_W-1:0] key_rdata;

    rect_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_key_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (key_rdata)
    );

    // Control conditions
    logic round_end;
    logic last_round;
    logic out_free;
    logic advance;
    logic deliver;
    logic key_in_range;

    assign round_end    = (digit_reg == DCNT_W'(DIGITS - 1));
    assign last_round   = (round_reg == AW'(1));
    assign out_free     = !out_valid_reg || m_axis_tready;
    assign advance      = !(round_end && last_round && !out_free);
    assign key_in_range = (CW'(in_key_index) <= CW'(ROUNDS));

    // S-box slice: taps realise the inverse rotations on the rotating rows
    row_t       tap_b, tap_d, tap_e;
    col_slice_t slice;
    row_t       nxt_shift [ROWS];
    row_t       key_row [ROWS];

    assign tap_b = rotr_row(cur_reg[1], ROT_B);
    assign tap_d = rotr_row(cur_reg[2], ROT_D);
    assign tap_e = rotr_row(cur_reg[3], ROT_E);
    assign slice = inv_sbox(cur_reg[0][DIGIT_W-1:0], tap_b[DIGIT_W-1:0],
                            tap_d[DIGIT_W-1:0], tap_e[DIGIT_W-1:0]);

    assign nxt_shift[0] = {slice.a, nxt_reg[0][ROW_W-1:DIGIT_W]};
    assign nxt_shift[1] = {slice.b, nxt_reg[1][ROW_W-1:DIGIT_W]};
    assign nxt_shift[2] = {slice.d, nxt_reg[2][ROW_W-1:DIGIT_W]};
    assign nxt_shift[3] = {slice.e, nxt_reg[3][ROW_W-1:DIGIT_W]};

    for (genvar g = 0; g < ROWS; g++)
    begin : g_key_rows
        assign key_row[g] = key_rdata[g*ROW_W +: ROW_W];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_action == ACT_DECRYPT))
                begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_end && last_round && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = AW'(in_key_index);
        ram_re        = 1'b0;
        ram_raddr     = AW'(ROUNDS);
        deliver       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_we        = in_accept && (in_action == ACT_LOAD) && key_in_range;
                ram_re        = in_accept && (in_action == ACT_DECRYPT);
                ram_raddr     = AW'(ROUNDS);
            end
            ST_KEY:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(ROUNDS - 1);
            end
            ST_ROUND:
            begin
                // fetch the key that ends the next round
                ram_re    = round_end && advance && !last_round;
                ram_raddr = AW'(round_reg - AW'(2));
                deliver   = round_end && last_round && out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath and counters
    always_comb
    begin
        round_next    = round_reg;
        digit_next    = digit_reg;
        out_data_next = out_data_reg;
        for (int i = 0; i < ROWS; i++)
        begin
            cur_next[i] = cur_reg[i];
            nxt_next[i] = nxt_reg[i];
        end

        if (in_accept && (in_action == ACT_DECRYPT))
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                cur_next[i] = in_block[i*ROW_W +: ROW_W];
            end
        end

        if (state_reg == ST_KEY)
        begin
            round_next = AW'(ROUNDS);
            digit_next = '0;
            for (int i = 0; i < ROWS; i++)
            begin
                cur_next[i] = cur_reg[i] ^ key_row[i];
            end
        end

        if ((state_reg == ST_ROUND) && advance)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                nxt_next[i] = nxt_shift[i];
            end
            if (round_end)
            begin
                digit_next = '0;
                round_next = round_reg - AW'(1);
                for (int i = 0; i < ROWS; i++)
                begin
                    cur_next[i] = nxt_shift[i] ^ key_row[i];
                end
            end
            else
            begin
                digit_next = digit_reg + DCNT_W'(1);
                for (int i = 0; i < ROWS; i++)
                begin
                    cur_next[i] = rotr_row(cur_reg[i], DIGIT_W);
                end
            end
        end

        if (deliver)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                out_data_next[i*ROW_W +: ROW_W] = nxt_shift[i] ^ key_row[i];
            end
        end
    end

    assign out_valid_next = (out_valid_reg && !m_axis_tready) || deliver;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            digit_reg     <= digit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            cur_reg[i] <= cur_next[i];
            nxt_reg[i] <= nxt_next[i];
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    property p_round_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> ((round_reg != AW'(0)) && (round_reg <= AW'(ROUNDS)));
    endproperty
    a_round_range: assert property (p_round_range)
        else $error("round counter out of range");

    property p_decrypt_start;
        @(posedge clk) disable iff (!rst_n)
        (in_accept && (in_action == ACT_DECRYPT)) |=> (state_reg == ST_KEY);
    endproperty
    a_decrypt_start: assert property (p_decrypt_start)
        else $error("decrypt transaction did not start a key fetch");

    property p_round_entry;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |=>
            ((state_reg == ST_ROUND) && (round_reg == AW'(ROUNDS)) && (digit_reg == '0));
    endproperty
    a_round_entry: assert property (p_round_entry)
        else $error("rounds did not start from the top");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(out_data_reg);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("pending result overwritten");

endmodule

// File: verif/rectangle_block_decrypt_tb.sv
// ---------------------------------------------------------------------------
// rectangle_block_decrypt_tb
// Self-checking bench for the RECTANGLE-64 decryption core. Round keys are
// loaded over the input stream. Every ciphertext accepted is decrypted by a
// behavioural copy of the cipher held here, and each plaintext that leaves the core
// is compared in order against it. Both stream sides stall at random while idling is on.
// ---------------------------------------------------------------------------
module rectangle_block_decrypt_tb;
    import rect_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_SLOTS      = RECT_ROUNDS + 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // key_index [4:0], key_value [68:5], block_in [132:69], zero fill above
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    // action [0]
    logic                  s_axis_tuser  = ACT_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // block_out [63:0]
    logic [BLOCK_W-1:0]    m_axis_tdata;

    logic [BLOCK_W-1:0] round_keys [KEY_SLOTS];
    logic [BLOCK_W-1:0] pending_plaintext [$];
    logic [BLOCK_W-1:0] want_block;
    int                 mismatch_count = 0;
    bit                 idling_on      = 1'b1;
    int                 stall_left     = 0;

    rectangle_block_decrypt u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Run the 25 inverse rounds from the highest key down, then whiten with key 0
    function automatic logic [BLOCK_W-1:0] predict_plaintext(input logic [BLOCK_W-1:0] cipher);
        logic [ROW_W-1:0]   r0;
        logic [ROW_W-1:0]   r1;
        logic [ROW_W-1:0]   r2;
        logic [ROW_W-1:0]   r3;
        logic [ROW_W-1:0]   tmp;
        logic [BLOCK_W-1:0] rk;
        r0 = cipher[15:0];
        r1 = cipher[31:16];
        r2 = cipher[47:32];
        r3 = cipher[63:48];
        for (int rnd = RECT_ROUNDS; rnd > 0; rnd--)
        begin
            rk = round_keys[rnd];
            r0 = r0 ^ rk[15:0];
            r1 = r1 ^ rk[31:16];
            r2 = r2 ^ rk[47:32];
            r3 = r3 ^ rk[63:48];
            r1 = {r1[0], r1[15:1]};
            r2 = {r2[11:0], r2[15:12]};
            r3 = {r3[12:0], r3[15:13]};
            tmp = r0;
            r0  = r0 & r2;
            r0  = r0 ^ r3;
            r3  = r3 | tmp;
            r3  = r3 ^ r2;
            r1  = r1 ^ r3;
            r2  = r1;
            r1  = r1 ^ tmp;
            r1  = r1 ^ r0;
            r3  = ~r3;
            tmp = r3;
            r3  = r3 | r1;
            r3  = r3 ^ r0;
            r0  = r0 & r1;
            r0  = r0 ^ tmp;
        end
        rk = round_keys[0];
        return {r3 ^ rk[63:48], r2 ^ rk[47:32], r1 ^ rk[31:16], r0 ^ rk[15:0]};
    endfunction

    function automatic logic [BLOCK_W-1:0] rand_word64();
        return {$urandom(), $urandom()};
    endfunction

    // Hold the transaction until accepted, then update the key copy or queue the plaintext
    task automatic send_item(input logic act, input logic [KEY_IDX_W-1:0] idx,
                             input logic [BLOCK_W-1:0] kval, input logic [BLOCK_W-1:0] blk);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word = '0;
        word[KEY_IDX_W-1:0]              = idx;
        word[KEY_IDX_W +: BLOCK_W]       = kval;
        word[KEY_IDX_W+BLOCK_W +: BLOCK_W] = blk;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= act;
        do @(posedge clk); while (!s_axis_tready);
        if (act == ACT_DECRYPT)
            pending_plaintext.push_back(predict_plaintext(blk));
        else if (idx <= RECT_ROUNDS)
            round_keys[idx] = kval;
    endtask

    task automatic test_key_load();
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (i == 0)
                send_item(ACT_LOAD, KEY_IDX_W'(i), '0, rand_word64());
            else if (i == RECT_ROUNDS)
                send_item(ACT_LOAD, KEY_IDX_W'(i), '1, rand_word64());
            else
                send_item(ACT_LOAD, KEY_IDX_W'(i), rand_word64(), rand_word64());
        end
    endtask

    // Indexes past the last round must leave the key RAM untouched
    task automatic test_dropped_index();
        for (int i = RECT_ROUNDS + 1; i < 32; i++)
            send_item(ACT_LOAD, KEY_IDX_W'(i), (i == 31) ? '1 : rand_word64(), '1);
    endtask

    task automatic test_edge_blocks();
        send_item(ACT_DECRYPT, '0, '0, '0);
        send_item(ACT_DECRYPT, '0, '0, '1);
        send_item(ACT_DECRYPT, '0, '0, 64'h5555_5555_5555_5555);
        send_item(ACT_DECRYPT, '0, '0, 64'haaaa_aaaa_aaaa_aaaa);
        send_item(ACT_DECRYPT, '0, '0, 64'h8000_0001_8000_0001);
    endtask

    // Junk in the fields that the operation does not use
    task automatic test_unused_fields();
        send_item(ACT_DECRYPT, '1, '1, rand_word64());
        send_item(ACT_DECRYPT, 5'd7, rand_word64(), rand_word64());
        send_item(ACT_LOAD, 5'd0, '1, rand_word64());
        send_item(ACT_LOAD, KEY_IDX_W'(RECT_ROUNDS), '0, '1);
        send_item(ACT_DECRYPT, '0, '0, rand_word64());
    endtask

    task automatic test_random_traffic(input int n_items);
        int sel;
        for (int n = 0; n < n_items; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
                send_item(ACT_DECRYPT, KEY_IDX_W'($urandom()), rand_word64(), rand_word64());
            else if (sel < 93)
                send_item(ACT_LOAD, KEY_IDX_W'($urandom_range(0, RECT_ROUNDS)),
                          rand_word64(), rand_word64());
            else
                send_item(ACT_LOAD, KEY_IDX_W'($urandom_range(RECT_ROUNDS + 1, 31)),
                          rand_word64(), rand_word64());
        end
    endtask

    // Random bursts of output back-pressure, started only while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_plaintext.size() == 0)
            begin
                $error("block_out: expected no transaction, actual %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want_block = pending_plaintext.pop_front();
                if (m_axis_tdata !== want_block)
                begin
                    $error("block_out: expected %h, actual %h", want_block, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL rectangle_block_decrypt");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_load();
        test_dropped_index();
        test_edge_blocks();
        test_unused_fields();
        test_random_traffic(600);
        // a stretch with no idling on either side
        idling_on = 1'b0;
        test_random_traffic(150);
        idling_on = 1'b1;
        test_random_traffic(400);
        idling_on = 1'b0;
        test_random_traffic(300);

        s_axis_tvalid <= 1'b0;
        while (pending_plaintext.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS rectangle_block_decrypt");
        else
            $display("FAIL rectangle_block_decrypt");
        $finish;
    end

endmodule
